>>> src/scpa_pkg.sv
// ----------------------------------------------------------------------------
// scpa_pkg
// Shared types and fixed constants of the scratch page slot allocator.
// ----------------------------------------------------------------------------
package scpa_pkg;

    // Fixed field widths of the request and result ports.
    localparam int CMD_W    = 1;
    localparam int FRAME_W  = 40;
    localparam int VA_W     = 39;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 9;
    localparam int PTE_W    = 52;

    // Page geometry and the top of the scratch window.
    localparam int                PAGE_SHIFT = 12;
    localparam logic [FRAME_W-1:0] PAGE_SIZE  = 40'h00_0000_1000;
    localparam logic [FRAME_W-1:0] WINDOW_TOP = 40'h80_0000_0000;
    localparam logic [1:0]        PTE_FLAGS  = 2'b11;

    // Request opcodes.
    typedef enum logic [CMD_W-1:0] {
        CMD_RESERVE = 1'b0,
        CMD_FREE    = 1'b1
    } t_cmd;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_BAD_ADDR = 2'd2
    } t_status;

    // Request sequencer states.
    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_MODIFY = 1'b1
    } t_state;

endpackage

>>> src/scratch_page_slot_allocator.sv
// ----------------------------------------------------------------------------
// scratch_page_slot_allocator
// First-fit allocator of scratch virtual page slots below the 512 GiB line.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Every request is a
// read-modify-write: the bitmap word it touches is read from the bitmap memory at the
// accepting edge, modified and written back at the next edge, and the result
// is shown on the o_ ports with o_valid for exactly one cycle after that. busy
// is high for the one cycle of the read-modify-write, so a new request can be
// taken in the cycle the previous result is shown. The receiver cannot stall
// the block and must capture the result in its o_valid cycle. The bitmap
// comes out of reset empty at once, with no clearing pass.
// ----------------------------------------------------------------------------
module scratch_page_slot_allocator #(
    parameter int BITMAP_WORDS = 8,
    parameter int WORD_BITS    = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [scpa_pkg::CMD_W-1:0]    i_command,
    input  logic [scpa_pkg::FRAME_W-1:0]  i_phys_frame,
    input  logic [scpa_pkg::VA_W-1:0]     i_free_virt_addr,
    output logic                          o_valid,
    output scpa_pkg::t_status             o_status,
    output logic [scpa_pkg::SLOT_W-1:0]   o_slot_index,
    output logic [scpa_pkg::PTE_W-1:0]    o_pte_value,
    output logic [scpa_pkg::VA_W-1:0]     o_virt_addr
);
    import scpa_pkg::*;

    localparam int SLOTS  = BITMAP_WORDS * WORD_BITS;
    localparam int WW     = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int BW     = $clog2(WORD_BITS);
    localparam int SI_W   = $clog2(SLOTS);
    localparam logic [FRAME_W-1:0] WIN_BASE_F = WINDOW_TOP - FRAME_W'(SLOTS) * PAGE_SIZE;
    localparam logic [VA_W-1:0]    WIN_BASE   = WIN_BASE_F[VA_W-1:0];

    t_state              r_state;
    t_state              n_state;
    logic                acc;
    logic                mem_we;
    logic [WW-1:0]       rd_addr;
    logic [WORD_BITS-1:0] rd_data;
    logic [WORD_BITS-1:0] wr_data;
    logic                any_free;
    logic [WW-1:0]       first_free;

    // Free-address decode signals.
    logic [VA_W-1:0]     dec_offs;
    logic                dec_ok;
    logic [SI_W-1:0]     dec_slot;
    logic [WW-1:0]       dec_word;
    logic [SI_W-1:0]     dec_word_base;
    logic [BW-1:0]       dec_bit;

    // Request registers held through the modify cycle.
    t_cmd                r_cmd;
    logic [FRAME_W-1:0]  r_frame;
    logic [WW-1:0]       r_word;
    logic [BW-1:0]       r_bit;
    logic [SI_W-1:0]     r_slot;
    logic                r_addr_ok;
    logic                r_none_free;

    // Modify-cycle signals.
    logic [BW-1:0]       zero_bit;
    logic [SI_W-1:0]     res_slot;
    logic [SI_W+SLOT_W-1:0] res_slot_ext;
    logic [VA_W-1:0]     res_va;

    // Result registers.
    logic                r_valid;
    t_status             r_status;
    logic [SLOT_W-1:0]   r_slot_index;
    logic [PTE_W-1:0]    r_pte_value;
    logic [VA_W-1:0]     r_virt_addr;

    assign acc = start && !busy;

    // Window check and slot decode of a free address.
    always_comb begin
        dec_offs = i_free_virt_addr - WIN_BASE;
        dec_ok   = (i_free_virt_addr >= WIN_BASE) &&
                   (i_free_virt_addr[PAGE_SHIFT-1:0] == '0);
        dec_slot = dec_offs[PAGE_SHIFT +: SI_W];
        dec_word = '0;
        for (int k = 1; k < BITMAP_WORDS; k++) begin
            if (dec_slot >= SI_W'(k * WORD_BITS)) begin
                dec_word = WW'(k);
            end
        end
        dec_word_base = SI_W'(dec_word) * SI_W'(WORD_BITS);
        dec_bit       = BW'(dec_slot - dec_word_base);
    end

    // Word to read: lowest non-full word on reserve, decoded word on free.
    assign rd_addr = (t_cmd'(i_command) == CMD_RESERVE) ? first_free : dec_word;

    scpa_bitmap_mem #(
        .DEPTH  (BITMAP_WORDS),
        .WIDTH  (WORD_BITS),
        .ADDR_W (WW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (acc),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (mem_we),
        .i_wr_addr (r_word),
        .i_wr_data (wr_data)
    );

    scpa_summary #(
        .WORDS  (BITMAP_WORDS),
        .ADDR_W (WW)
    ) u_summary (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_upd_en     (mem_we),
        .i_upd_word   (r_word),
        .i_upd_full   (&wr_data),
        .o_any_free   (any_free),
        .o_first_free (first_free)
    );

    // Capture the request at acceptance.
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_cmd       <= t_cmd'(i_command);
            r_frame     <= i_phys_frame;
            r_word      <= rd_addr;
            r_bit       <= dec_bit;
            r_slot      <= dec_slot;
            r_addr_ok   <= dec_ok;
            r_none_free <= !any_free;
        end
    end

    // Lowest clear bit of the word read back.
    always_comb begin
        zero_bit = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!rd_data[i]) begin
                zero_bit = BW'(i);
            end
        end
    end

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (acc) n_state = ST_MODIFY;
            ST_MODIFY: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs: busy flag and bitmap write-back.
    always_comb begin
        busy    = 1'b0;
        mem_we  = 1'b0;
        wr_data = rd_data;
        unique case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
            end
            ST_MODIFY: begin
                busy = 1'b1;
                if (r_cmd == CMD_RESERVE) begin
                    mem_we  = !r_none_free;
                    wr_data = rd_data | (WORD_BITS'(1) << zero_bit);
                end else begin
                    mem_we  = r_addr_ok;
                    wr_data = rd_data & ~(WORD_BITS'(1) << r_bit);
                end
            end
            default: begin
                busy = 1'b0;
            end
        endcase
    end

    // Slot of a reserved or freed slot, and address of a reserved slot.
    always_comb begin
        if (r_cmd == CMD_RESERVE) begin
            res_slot = SI_W'(r_word) * SI_W'(WORD_BITS) + SI_W'(zero_bit);
        end else begin
            res_slot = r_slot;
        end
        res_slot_ext = (SI_W + SLOT_W)'(res_slot);
        res_va       = WIN_BASE + (VA_W'(res_slot) << PAGE_SHIFT);
    end

    // Result registers, loaded at the end of the modify cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (r_state == ST_MODIFY);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_MODIFY) begin
            if (r_cmd == CMD_RESERVE && r_none_free) begin
                r_status     <= STAT_FULL;
                r_slot_index <= '0;
                r_pte_value  <= '0;
                r_virt_addr  <= '0;
            end else if (r_cmd == CMD_RESERVE) begin
                r_status     <= STAT_OK;
                r_slot_index <= res_slot_ext[SLOT_W-1:0];
                r_pte_value  <= {r_frame, {(PAGE_SHIFT - 2){1'b0}}, PTE_FLAGS};
                r_virt_addr  <= res_va;
            end else if (!r_addr_ok) begin
                r_status     <= STAT_BAD_ADDR;
                r_slot_index <= '0;
                r_pte_value  <= '0;
                r_virt_addr  <= '0;
            end else begin
                r_status     <= STAT_OK;
                r_slot_index <= res_slot_ext[SLOT_W-1:0];
                r_pte_value  <= '0;
                r_virt_addr  <= '0;
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_slot_index = r_slot_index;
    assign o_pte_value  = r_pte_value;
    assign o_virt_addr  = r_virt_addr;

    // A result appears in the cycle after each modify cycle.
    a_result_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MODIFY) |=> o_valid)
        else $error("result strobe missing after modify cycle");

    a_no_stray_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == ST_MODIFY))
        else $error("result strobe without a request");

    // The summary must never point a reserve at a word that is already full.
    a_summary_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MODIFY && r_cmd == CMD_RESERVE && !r_none_free)
            |-> !(&rd_data))
        else $error("summary selected a full bitmap word");

    // A reserve write-back claims exactly one new slot.
    a_reserve_one_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && r_cmd == CMD_RESERVE)
            |-> ($countones(wr_data) == $countones(rd_data) + 1))
        else $error("reserve changed other than one bit");

endmodule

>>> src/scpa_bitmap_mem.sv
// ----------------------------------------------------------------------------
// scpa_bitmap_mem
// Occupancy bitmap storage: one write port, one read port with a registered
// read, and a valid bit per word so that unwritten words read as all free.
// ----------------------------------------------------------------------------
module scpa_bitmap_mem #(
    parameter int DEPTH  = 8,
    parameter int WIDTH  = 64,
    parameter int ADDR_W = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] r_word_vld;
    logic [WIDTH-1:0] r_rd_data;
    logic             r_rd_vld;

    // Storage array: written and read in a clocked block.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    // Per-word valid bits and the registered validity of the last read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_vld <= '0;
            r_rd_vld   <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_word_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_word_vld[i_rd_addr];
            end
        end
    end

    // A word never written holds no used slots.
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

>>> src/scpa_summary.sv
// ----------------------------------------------------------------------------
// scpa_summary
// Per-word full flags of the bitmap and the search for the lowest word that
// still has a free slot.
// ----------------------------------------------------------------------------
module scpa_summary #(
    parameter int WORDS  = 8,
    parameter int ADDR_W = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_upd_en,
    input  logic [ADDR_W-1:0] i_upd_word,
    input  logic              i_upd_full,
    output logic              o_any_free,
    output logic [ADDR_W-1:0] o_first_free
);

    logic [WORDS-1:0] r_full;

    // Flag update on every bitmap write-back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= '0;
        end else if (i_upd_en) begin
            r_full[i_upd_word] <= i_upd_full;
        end
    end

    // Lowest word whose flag is clear.
    always_comb begin
        o_first_free = '0;
        for (int i = WORDS - 1; i >= 0; i--) begin
            if (!r_full[i]) begin
                o_first_free = ADDR_W'(i);
            end
        end
    end

    assign o_any_free = ~(&r_full);

endmodule
